// ===== design/client_connection_handshake_fsm_macros.svh =====
// assertion macros shared by the checker file
`ifndef CLIENT_CONNECTION_HANDSHAKE_FSM_MACROS_SVH
`define CLIENT_CONNECTION_HANDSHAKE_FSM_MACROS_SVH

// same-cycle implication, reset masked
`define CCH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cch assertion failed");

// next-cycle implication, reset masked
`define CCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cch assertion failed");

`endif

// ===== design/cch_pkg.sv =====
// shared types and constants for the client connection handshake block
package cch_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int ADDR_WIDTH_DEF = 64;
	localparam int SALT_W         = 64;
	localparam int CFG_W          = 20;
	localparam int NUM_CFG        = 7;
	localparam int CFG_IDX_W      = 3;
	localparam int MODE_W         = 3;
	localparam int KIND_W         = 2;
	localparam int LINK_W         = 4;
	localparam int QDEPTH         = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REQ_SEND  = 3'd0,
		CFG_RESP_SEND = 3'd1,
		CFG_KA_SEND   = 3'd2,
		CFG_REQ_TMO   = 3'd3,
		CFG_RESP_TMO  = 3'd4,
		CFG_KA_TMO    = 3'd5,
		CFG_SALT_LIFE = 3'd6
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
		20'd100, 20'd100, 20'd1000, 20'd5000, 20'd5000, 20'd10000, 20'd1000
	};

	typedef enum logic [MODE_W-1:0] {
		MODE_CONNECT       = 3'd0,
		MODE_DISCONNECT    = 3'd1,
		MODE_POLL          = 3'd2,
		MODE_TIMEOUT       = 3'd3,
		MODE_RX_DENIED     = 3'd4,
		MODE_RX_CHALLENGE  = 3'd5,
		MODE_RX_KEEPALIVE  = 3'd6,
		MODE_RX_DISCONNECT = 3'd7
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		TX_REQ  = 2'd0,
		TX_RESP = 2'd1,
		TX_KA   = 2'd2,
		TX_DISC = 2'd3
	} txk_t;

	localparam logic [LINK_W-1:0] LINK_IDLE      = 4'd0;
	localparam logic [LINK_W-1:0] LINK_REQ       = 4'd1;
	localparam logic [LINK_W-1:0] LINK_RESP      = 4'd2;
	localparam logic [LINK_W-1:0] LINK_CONN      = 4'd3;
	localparam logic [LINK_W-1:0] LINK_REQ_TO    = 4'd4;
	localparam logic [LINK_W-1:0] LINK_RESP_TO   = 4'd5;
	localparam logic [LINK_W-1:0] LINK_KA_TO     = 4'd6;
	localparam logic [LINK_W-1:0] LINK_DENY_FULL = 4'd7;
	localparam logic [LINK_W-1:0] LINK_DENY_DUP  = 4'd8;

	// classified event handed from front to back
	typedef struct packed {
		mode_t op;
		logic  is_rx;
	} ev_t;

endpackage

// ===== design/client_connection_handshake_fsm.sv =====
// top level of the client connection handshake block
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tuser mode, s_tdata event fields
//  m_*       out        m_tvalid / m_tready  m_tuser packet flag+kind, m_tdata packet+state
//  cfg_*     in         cfg_we               cfg_index, cfg_wdata
//
// one word per clock sustained while m_tready is high; words reach m_tdata via the queue
// and the result register; the whole state update is combinational in the back end
// a two-entry queue sits between front and back, the result register holds one word
// m_tready low stalls the back end, the queue keeps s_tready high until it fills
// arst_n clears state, queue and configuration to their defaults at once
module client_connection_handshake_fsm #(
	parameter int TIME_WIDTH = cch_pkg::TIME_WIDTH_DEF,
	parameter int ADDR_WIDTH = cch_pkg::ADDR_WIDTH_DEF,
	parameter int IN_W  = ((TIME_WIDTH + ADDR_WIDTH + 3 * cch_pkg::SALT_W + 1 + 7) / 8) * 8,
	parameter int OUT_W = ((ADDR_WIDTH + 2 * cch_pkg::SALT_W + cch_pkg::LINK_W + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// now, peer_address, pkt_client_salt, pkt_challenge_salt, deny_reason, fresh_salt
	input  logic [IN_W-1:0]               s_tdata,
	// mode
	input  logic [cch_pkg::MODE_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// tx_dest, tx_client_salt, tx_challenge_salt, link_state
	output logic [OUT_W-1:0]              m_tdata,
	// tx_valid, tx_kind
	output logic [cch_pkg::KIND_W:0]      m_tuser,
	input  logic                          cfg_we,
	input  logic [cch_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cch_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int PAY_W  = TIME_WIDTH + ADDR_WIDTH + 3 * cch_pkg::SALT_W + 1;

	logic                           q_valid, q_ready;
	cch_pkg::ev_t                   q_ev;
	logic [PAY_W-1:0]               q_pay;
	logic                           txv;
	logic [cch_pkg::KIND_W-1:0]     kind;
	logic [ADDR_WIDTH-1:0]          dest;
	logic [cch_pkg::SALT_W-1:0]     cs, ch;
	logic [cch_pkg::LINK_W-1:0]     link;

	cch_front #(
		.PAY_W (PAY_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_mode   (s_tuser),
		.s_pay    (s_tdata[PAY_W-1:0]),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_ev     (q_ev),
		.q_pay    (q_pay)
	);

	cch_back #(
		.TIME_WIDTH (TIME_WIDTH),
		.ADDR_WIDTH (ADDR_WIDTH),
		.PAY_W      (PAY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_ev      (q_ev),
		.q_pay     (q_pay),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_txv   (txv),
		.out_kind  (kind),
		.out_dest  (dest),
		.out_cs    (cs),
		.out_ch    (ch),
		.out_link  (link)
	);

	assign m_tdata = OUT_W'({link, ch, cs, dest});
	assign m_tuser = {kind, txv};

endmodule

// ===== design/cch_front.sv =====
// front end: accepts input words, classifies the event and queues it
module cch_front #(
	parameter int PAY_W = 289
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cch_pkg::MODE_W-1:0]        s_mode,
	input  logic [PAY_W-1:0]                  s_pay,
	output logic                              q_valid,
	input  logic                              q_ready,
	output cch_pkg::ev_t                      q_ev,
	output logic [PAY_W-1:0]                  q_pay
);

	localparam int PTR_W = $clog2(cch_pkg::QDEPTH);
	localparam int CNT_W = $clog2(cch_pkg::QDEPTH + 1);

	cch_pkg::ev_t      ev_mem_q  [cch_pkg::QDEPTH];
	logic [PAY_W-1:0]  pay_mem_q [cch_pkg::QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	cch_pkg::ev_t      ev_in;
	logic              push, pop;

	always_comb begin
		ev_in.op    = cch_pkg::mode_t'(s_mode);
		ev_in.is_rx = (ev_in.op == cch_pkg::MODE_RX_DENIED) ||
			(ev_in.op == cch_pkg::MODE_RX_CHALLENGE) ||
			(ev_in.op == cch_pkg::MODE_RX_KEEPALIVE) ||
			(ev_in.op == cch_pkg::MODE_RX_DISCONNECT);
	end

	assign s_tready = (cnt_q != CNT_W'(cch_pkg::QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;
	assign q_ev     = ev_mem_q[rd_ptr_q];
	assign q_pay    = pay_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ev_mem_q[wr_ptr_q]  <= ev_in;
			pay_mem_q[wr_ptr_q] <= s_pay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(cch_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(cch_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/cch_back.sv =====
// back end: link state machine, timers, configuration and result register
module cch_back #(
	parameter int TIME_WIDTH = cch_pkg::TIME_WIDTH_DEF,
	parameter int ADDR_WIDTH = cch_pkg::ADDR_WIDTH_DEF,
	parameter int PAY_W      = TIME_WIDTH + ADDR_WIDTH + 3 * cch_pkg::SALT_W + 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cch_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cch_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             q_valid,
	output logic                             q_ready,
	input  cch_pkg::ev_t                     q_ev,
	input  logic [PAY_W-1:0]                 q_pay,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             out_txv,
	output logic [cch_pkg::KIND_W-1:0]       out_kind,
	output logic [ADDR_WIDTH-1:0]            out_dest,
	output logic [cch_pkg::SALT_W-1:0]       out_cs,
	output logic [cch_pkg::SALT_W-1:0]       out_ch,
	output logic [cch_pkg::LINK_W-1:0]       out_link
);

	localparam int SW    = cch_pkg::SALT_W;
	localparam int CMP_W = (TIME_WIDTH > cch_pkg::CFG_W) ? TIME_WIDTH : cch_pkg::CFG_W;
	localparam int O_PEER = TIME_WIDTH;
	localparam int O_PCS  = O_PEER + ADDR_WIDTH;
	localparam int O_PCH  = O_PCS + SW;
	localparam int O_DENY = O_PCH + SW;
	localparam int O_FRSH = O_DENY + 1;

	typedef enum logic [cch_pkg::LINK_W-1:0] {
		ST_IDLE      = cch_pkg::LINK_IDLE,
		ST_REQ       = cch_pkg::LINK_REQ,
		ST_RESP      = cch_pkg::LINK_RESP,
		ST_CONN      = cch_pkg::LINK_CONN,
		ST_REQ_TO    = cch_pkg::LINK_REQ_TO,
		ST_RESP_TO   = cch_pkg::LINK_RESP_TO,
		ST_KA_TO     = cch_pkg::LINK_KA_TO,
		ST_DENY_FULL = cch_pkg::LINK_DENY_FULL,
		ST_DENY_DUP  = cch_pkg::LINK_DENY_DUP
	} state_t;

	logic [cch_pkg::CFG_W-1:0] cfg_q [cch_pkg::NUM_CFG];
	state_t                    st_q, st_d;
	logic [ADDR_WIDTH-1:0]     addr_q, addr_d;
	logic [SW-1:0]             salt_q, salt_d, chal_q, chal_d;
	logic [TIME_WIDTH-1:0]     send_q, send_d, recv_q, recv_d, exp_q, exp_d;
	logic                      out_vld_q, out_txv_q;
	cch_pkg::txk_t             out_kind_q;
	logic [ADDR_WIDTH-1:0]     out_dest_q;
	logic [SW-1:0]             out_cs_q, out_ch_q;
	state_t                    out_link_q;

	logic [TIME_WIDTH-1:0]     now, d_send, d_recv, d_exp, send_bd, exp_new;
	logic [ADDR_WIDTH-1:0]     peer;
	logic [SW-1:0]             pcs, pch, fresh;
	logic                      deny;
	logic [CMP_W-1:0]          ss, sr, bd_w, ex_w;
	logic                      cs_ok, all_ok, fire;
	logic                      txv;
	cch_pkg::txk_t             kind;
	logic [ADDR_WIDTH-1:0]     dest;
	logic [SW-1:0]             cs, ch;

	assign now   = q_pay[TIME_WIDTH-1:0];
	assign peer  = q_pay[O_PCS-1:O_PEER];
	assign pcs   = q_pay[O_PCH-1:O_PCS];
	assign pch   = q_pay[O_DENY-1:O_PCH];
	assign deny  = q_pay[O_DENY];
	assign fresh = q_pay[O_FRSH+SW-1:O_FRSH];

	assign d_send  = now - send_q;
	assign d_recv  = now - recv_q;
	assign d_exp   = now - exp_q;
	assign ss      = CMP_W'(d_send);
	assign sr      = CMP_W'(d_recv);
	assign bd_w    = CMP_W'(now) - CMP_W'(cfg_q[cch_pkg::CFG_KA_SEND]);
	assign ex_w    = CMP_W'(now) + CMP_W'(cfg_q[cch_pkg::CFG_SALT_LIFE]);
	assign send_bd = bd_w[TIME_WIDTH-1:0];
	assign exp_new = ex_w[TIME_WIDTH-1:0];

	assign cs_ok  = q_ev.is_rx && (pcs == salt_q) && (peer == addr_q);
	assign all_ok = cs_ok && (pch == chal_q);

	assign q_ready = !out_vld_q || out_ready;
	assign fire    = q_valid && q_ready;

	always_comb begin
		st_d   = st_q;
		addr_d = addr_q;
		salt_d = salt_q;
		chal_d = chal_q;
		send_d = send_q;
		recv_d = recv_q;
		exp_d  = exp_q;
		txv    = 1'b0;
		kind   = cch_pkg::TX_REQ;
		dest   = '0;
		cs     = '0;
		ch     = '0;
		unique case (q_ev.op)
			cch_pkg::MODE_CONNECT, cch_pkg::MODE_DISCONNECT,
			cch_pkg::MODE_RX_DISCONNECT: begin
				if (q_ev.op != cch_pkg::MODE_RX_DISCONNECT || (st_q == ST_CONN && all_ok)) begin
					if (st_q == ST_CONN) begin
						txv  = 1'b1;
						kind = cch_pkg::TX_DISC;
						dest = addr_q;
						cs   = salt_q;
						ch   = chal_q;
					end
					st_d   = ST_IDLE;
					addr_d = '0;
					salt_d = '0;
					chal_d = '0;
					send_d = '0;
					recv_d = '0;
					exp_d  = '0;
					if (q_ev.op == cch_pkg::MODE_CONNECT) begin
						st_d   = ST_REQ;
						addr_d = peer;
						salt_d = fresh;
						send_d = send_bd;
						recv_d = now;
						exp_d  = exp_new;
					end
				end
			end
			cch_pkg::MODE_POLL: begin
				unique case (st_q)
					ST_REQ: begin
						if (ss >= CMP_W'(cfg_q[cch_pkg::CFG_REQ_SEND])) begin
							txv  = 1'b1;
							kind = cch_pkg::TX_REQ;
						end
					end
					ST_RESP: begin
						if (ss >= CMP_W'(cfg_q[cch_pkg::CFG_RESP_SEND])) begin
							txv  = 1'b1;
							kind = cch_pkg::TX_RESP;
						end
					end
					ST_CONN: begin
						if (ss >= CMP_W'(cfg_q[cch_pkg::CFG_KA_SEND])) begin
							txv  = 1'b1;
							kind = cch_pkg::TX_KA;
						end
					end
					default: ;
				endcase
				if (txv) begin
					dest   = addr_q;
					cs     = salt_q;
					ch     = (kind == cch_pkg::TX_REQ) ? '0 : chal_q;
					send_d = now;
				end
			end
			cch_pkg::MODE_TIMEOUT: begin
				unique case (st_q)
					ST_REQ: begin
						if (sr > CMP_W'(cfg_q[cch_pkg::CFG_REQ_TMO])) begin
							st_d = ST_REQ_TO;
						end else if (d_exp != '0 && !d_exp[TIME_WIDTH-1]) begin
							salt_d = fresh;
							exp_d  = exp_new;
						end
					end
					ST_RESP: begin
						if (sr > CMP_W'(cfg_q[cch_pkg::CFG_RESP_TMO])) begin
							st_d = ST_RESP_TO;
						end
					end
					ST_CONN: begin
						if (sr > CMP_W'(cfg_q[cch_pkg::CFG_KA_TMO])) begin
							st_d   = ST_KA_TO;
							addr_d = '0;
							salt_d = '0;
							chal_d = '0;
							send_d = '0;
							recv_d = '0;
							exp_d  = '0;
						end
					end
					default: ;
				endcase
			end
			cch_pkg::MODE_RX_DENIED: begin
				if (st_q == ST_REQ && cs_ok) begin
					st_d = deny ? ST_DENY_DUP : ST_DENY_FULL;
				end
			end
			cch_pkg::MODE_RX_CHALLENGE: begin
				if (st_q == ST_REQ && cs_ok) begin
					chal_d = pch;
					st_d   = ST_RESP;
					recv_d = now;
				end
			end
			cch_pkg::MODE_RX_KEEPALIVE: begin
				if (st_q >= ST_RESP && all_ok) begin
					if (st_q == ST_RESP) begin
						st_d = ST_CONN;
					end
					recv_d = now;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cch_pkg::NUM_CFG; i++) begin
				cfg_q[i] <= cch_pkg::CFG_RESET[i];
			end
		end else if (cfg_we && cfg_index < cch_pkg::CFG_IDX_W'(cch_pkg::NUM_CFG)) begin
			cfg_q[cfg_index] <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			addr_q     <= '0;
			salt_q     <= '0;
			chal_q     <= '0;
			send_q     <= '0;
			recv_q     <= '0;
			exp_q      <= '0;
			out_vld_q  <= 1'b0;
			out_txv_q  <= 1'b0;
			out_kind_q <= cch_pkg::TX_REQ;
			out_dest_q <= '0;
			out_cs_q   <= '0;
			out_ch_q   <= '0;
			out_link_q <= ST_IDLE;
		end else begin
			if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (fire) begin
				st_q       <= st_d;
				addr_q     <= addr_d;
				salt_q     <= salt_d;
				chal_q     <= chal_d;
				send_q     <= send_d;
				recv_q     <= recv_d;
				exp_q      <= exp_d;
				out_vld_q  <= 1'b1;
				out_txv_q  <= txv;
				out_kind_q <= kind;
				out_dest_q <= dest;
				out_cs_q   <= cs;
				out_ch_q   <= ch;
				out_link_q <= st_d;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_txv   = out_txv_q;
	assign out_kind  = out_kind_q;
	assign out_dest  = out_dest_q;
	assign out_cs    = out_cs_q;
	assign out_ch    = out_ch_q;
	assign out_link  = out_link_q;

endmodule

// ===== design/cch_checker.sv =====
// port-level assertions for the client connection handshake block and its bind
`include "client_connection_handshake_fsm_macros.svh"

module cch_checker #(
	parameter int ADDR_WIDTH = cch_pkg::ADDR_WIDTH_DEF,
	parameter int OUT_W = ((ADDR_WIDTH + 2 * cch_pkg::SALT_W + cch_pkg::LINK_W + 7) / 8) * 8
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [OUT_W-1:0]              m_tdata,
	input logic [cch_pkg::KIND_W:0]      m_tuser
);

	localparam int TXF_W = ADDR_WIDTH + 2 * cch_pkg::SALT_W;
	localparam int CH_LO = ADDR_WIDTH + cch_pkg::SALT_W;

	logic                       pkt;
	logic [cch_pkg::KIND_W-1:0] kind;
	logic [cch_pkg::LINK_W-1:0] link;

	assign pkt  = m_tvalid && m_tuser[0];
	assign kind = m_tuser[cch_pkg::KIND_W:1];
	assign link = m_tdata[TXF_W+cch_pkg::LINK_W-1:TXF_W];

	// stalled result word holds
	`CCH_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// no packet means empty packet fields
	`CCH_ASSERT_NOW(a_no_pkt_zero, clk, arst_n, m_tvalid && !m_tuser[0], kind == '0 && m_tdata[TXF_W-1:0] == '0)

	// requests only go out while requesting, without a challenge salt
	`CCH_ASSERT_NOW(a_req_state, clk, arst_n, pkt && kind == cch_pkg::TX_REQ, link == cch_pkg::LINK_REQ && m_tdata[TXF_W-1:CH_LO] == '0)

	// a disconnect packet leaves the link idle or restarted
	`CCH_ASSERT_NOW(a_disc_state, clk, arst_n, pkt && kind == cch_pkg::TX_DISC, link == cch_pkg::LINK_IDLE || link == cch_pkg::LINK_REQ)

endmodule

bind client_connection_handshake_fsm cch_checker #(
	.ADDR_WIDTH (ADDR_WIDTH)
) u_cch_checker (.*);
